// ===== design/lbs_pkg.sv =====
// Package: shared types and constants for the linear blend skinning core.
`default_nettype none
package lbs_pkg;

	localparam int BONES    = 256;
	localparam int ELEMS    = 16;
	localparam int LANES    = 4;
	localparam int BONE_W   = 8;
	localparam int ELEM_W   = 4;
	localparam int WGT_W    = 16;
	localparam int CNT_W    = 9;
	localparam int H_W      = 50;              // homogeneous coordinate width
	localparam int QBITS    = 32;              // quotient bits, one per stage
	localparam int DIV_LAT  = QBITS + 3;       // abs, range check, bits, saturate
	localparam int PROD_W   = 49;              // Q18.31 weighted term
	localparam int ACC_W    = 52;              // sum over all lanes
	localparam int LAT      = DIV_LAT + 6;     // accept to result strobe

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_SKIN  = 1'b1;

	typedef struct packed {
		logic               operation;
		logic [7:0]         bone_index;
		logic [3:0]         element_index;
		logic signed [31:0] element_value;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [31:0]        joint_indices;
		logic [63:0]        weight_set;
	} item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               degenerate;
	} result_t;

	typedef struct packed {
		logic              en;
		logic [BONE_W-1:0] bone;
		logic [ELEM_W-1:0] elem;
		logic [31:0]       value;
	} mem_wr_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] x;
		logic signed [PROD_W-1:0] y;
		logic signed [PROD_W-1:0] z;
		logic                     degen;
	} lane_res_t;

endpackage
`default_nettype wire

// ===== design/linear_blend_vertex_skinning_core.sv =====
// A skin word's done strobe comes out through the lane, divider and merge registers; matrix writes give none.
// Throughput: one word per cycle; busy is never raised, the pipeline has no stall.
// Each lane holds a pipelined divider with 32 quotient-bit stages, one quotient bit per stage.
// Reset clears the bone count and the result strobe pipeline; the matrix banks hold
// whatever they held and must be written before use. The receiver cannot stall.
`default_nettype none
module linear_blend_vertex_skinning_core import lbs_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire item_t            item,
	input  wire logic             cfg_wr_en,
	input  wire logic [CNT_W-1:0] cfg_wr_data,
	output logic                  done,
	output result_t               result
);

	logic [CNT_W-1:0]      bone_count_q;
	logic [LAT-1:0]        vld_q;
	logic                  accept;
	mem_wr_t               wr;
	lane_res_t [LANES-1:0] lane_res;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// bone count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			bone_count_q <= '0;
		else if (cfg_wr_en)
			bone_count_q <= cfg_wr_data;
	end

	// matrix element write goes to every lane's banks
	assign wr.en    = accept && item.operation == OP_WRITE;
	assign wr.bone  = item.bone_index;
	assign wr.elem  = item.element_index;
	assign wr.value = item.element_value;

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic [BONE_W-1:0] jnt;
		logic [WGT_W-1:0]  wgt;
		assign jnt = item.joint_indices[BONE_W*l +: BONE_W];
		assign wgt = item.weight_set[WGT_W*l +: WGT_W];
		lbs_lane u_lane (
			.clk    (clk),
			.wr     (wr),
			.px     (item.pos_x),
			.py     (item.pos_y),
			.pz     (item.pos_z),
			.joint  (jnt),
			.weight (wgt),
			.active (wgt != '0 && {1'b0, jnt} < bone_count_q),
			.res    (lane_res[l])
		);
	end

	lbs_merge u_merge (
		.clk    (clk),
		.lane   (lane_res),
		.result (result)
	);

	// result strobe pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else
			vld_q <= {vld_q[LAT-2:0], accept && item.operation == OP_SKIN};
	end

	assign done = vld_q[LAT-1];

	// every accepted skin word yields its result strobe
	a_skin_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.operation == OP_SKIN |-> ##LAT done)
		else $error("skin word lost its result");

	// matrix writes never produce a result
	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.operation == OP_WRITE |-> ##LAT !done)
		else $error("matrix write produced a result");

	// a strobe always traces back to a skin word
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_q[LAT-2]))
		else $error("spurious result strobe");

endmodule
`default_nettype wire

// ===== design/lbs_div.sv =====
// Pipelined restoring divider: (num * 2^16) / den, truncated, saturated to 32 bits.
`default_nettype none
module lbs_div import lbs_pkg::*; (
	input  wire logic                  clk,
	input  wire logic signed [H_W-1:0] num,
	input  wire logic signed [H_W-1:0] den,
	output logic signed [31:0]         quo
);

	logic [H_W-1:0]   mag_a_q, dm_a_q;
	logic             neg_a_q;

	logic [H_W-1:0]   rem_s [0:QBITS];
	logic [QBITS-1:0] low_s [0:QBITS];
	logic [QBITS-1:0] q_s   [0:QBITS];
	logic [H_W-1:0]   d_s   [0:QBITS];
	logic             neg_s [0:QBITS];
	logic             ovf_s [0:QBITS];

	// magnitudes and result sign
	always_ff @(posedge clk) begin
		neg_a_q <= num[H_W-1] ^ den[H_W-1];
		mag_a_q <= num[H_W-1] ? H_W'(-num) : H_W'(num);
		dm_a_q  <= den[H_W-1] ? H_W'(-den) : H_W'(den);
	end

	// quotient of 2^32 or more saturates; the magnitude above bit 15 seeds the remainder
	always_ff @(posedge clk) begin
		ovf_s[0] <= {16'b0, mag_a_q} >= {dm_a_q, 16'b0};
		rem_s[0] <= {16'b0, mag_a_q[H_W-1:16]};
		low_s[0] <= {mag_a_q[15:0], 16'b0};
		q_s[0]   <= '0;
		d_s[0]   <= dm_a_q;
		neg_s[0] <= neg_a_q;
	end

	// one quotient bit per stage
	for (genvar i = 0; i < QBITS; i++) begin : g_bit
		logic [H_W:0] shl;
		logic         ge;
		assign shl = {rem_s[i], low_s[i][QBITS-1]};
		assign ge  = shl >= {1'b0, d_s[i]};
		always_ff @(posedge clk) begin
			rem_s[i+1] <= ge ? H_W'(shl - {1'b0, d_s[i]}) : shl[H_W-1:0];
			low_s[i+1] <= {low_s[i][QBITS-2:0], 1'b0};
			q_s[i+1]   <= {q_s[i][QBITS-2:0], ge};
			d_s[i+1]   <= d_s[i];
			neg_s[i+1] <= neg_s[i];
			ovf_s[i+1] <= ovf_s[i];
		end
	end

	// sign and saturation
	always_ff @(posedge clk) begin
		if (neg_s[QBITS]) begin
			if (ovf_s[QBITS] || q_s[QBITS] > 32'h8000_0000)
				quo <= 32'sh8000_0000;
			else
				quo <= 32'(-{1'b0, q_s[QBITS]});
		end else begin
			if (ovf_s[QBITS] || q_s[QBITS] > 32'h7FFF_FFFF)
				quo <= 32'sh7FFF_FFFF;
			else
				quo <= q_s[QBITS];
		end
	end

endmodule
`default_nettype wire

// ===== design/lbs_lane.sv =====
// One influence lane: matrix banks, transform, perspective divide, weighting.
`default_nettype none
module lbs_lane import lbs_pkg::*; (
	input  wire logic               clk,
	input  wire mem_wr_t            wr,
	input  wire logic signed [31:0] px,
	input  wire logic signed [31:0] py,
	input  wire logic signed [31:0] pz,
	input  wire logic [BONE_W-1:0]  joint,
	input  wire logic [WGT_W-1:0]   weight,
	input  wire logic               active,
	output lane_res_t               res
);

	logic signed [31:0] elem_s1 [0:ELEMS-1];
	logic signed [31:0] pos_s1  [0:2];
	logic [WGT_W-1:0]   w_s1, w_s2, w_s3;
	logic               act_s1, act_s2, act_s3;

	logic signed [63:0] mul_s2 [0:11];
	logic signed [31:0] t_s2   [0:3];
	logic signed [H_W-1:0] h_s3 [0:3];

	logic signed [31:0] quo [0:2];
	logic [WGT_W-1:0]   side_w [0:DIV_LAT-1];
	logic               side_a [0:DIV_LAT-1];
	logic               side_z [0:DIV_LAT-1];
	logic               use_w;

	// one bank per matrix element, so a whole bone reads at once
	for (genvar e = 0; e < ELEMS; e++) begin : g_bank
		logic [31:0] bank [0:BONES-1];
		always_ff @(posedge clk) begin
			if (wr.en && wr.elem == ELEM_W'(e))
				bank[wr.bone] <= wr.value;
			elem_s1[e] <= bank[joint];
		end
	end

	always_ff @(posedge clk) begin
		pos_s1[0] <= px;
		pos_s1[1] <= py;
		pos_s1[2] <= pz;
		w_s1      <= weight;
		act_s1    <= active;
	end

	// row vector times matrix: products
	for (genvar r = 0; r < 3; r++) begin : g_row
		for (genvar c = 0; c < 4; c++) begin : g_col
			always_ff @(posedge clk)
				mul_s2[r*4+c] <= pos_s1[r] * elem_s1[r*4+c];
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 4; c++)
			t_s2[c] <= elem_s1[12+c];
		w_s2   <= w_s1;
		act_s2 <= act_s1;
	end

	// floor each product to Q32.16 and add the translation row
	for (genvar c = 0; c < 4; c++) begin : g_sum
		always_ff @(posedge clk)
			h_s3[c] <= H_W'($signed(mul_s2[c][63:16])) + H_W'($signed(mul_s2[4+c][63:16]))
				+ H_W'($signed(mul_s2[8+c][63:16])) + H_W'(t_s2[c]);
	end

	always_ff @(posedge clk) begin
		w_s3   <= w_s2;
		act_s3 <= act_s2;
	end

	// divide x, y, z by w
	for (genvar c = 0; c < 3; c++) begin : g_div
		lbs_div u_div (
			.clk (clk),
			.num (h_s3[c]),
			.den (h_s3[3]),
			.quo (quo[c])
		);
	end

	// weight and flags travel beside the divider
	always_ff @(posedge clk) begin
		side_w[0] <= w_s3;
		side_a[0] <= act_s3;
		side_z[0] <= h_s3[3] == '0;
		for (int i = 1; i < DIV_LAT; i++) begin
			side_w[i] <= side_w[i-1];
			side_a[i] <= side_a[i-1];
			side_z[i] <= side_z[i-1];
		end
	end

	assign use_w = side_a[DIV_LAT-1] && !side_z[DIV_LAT-1];

	// weighted contribution, Q18.31
	always_ff @(posedge clk) begin
		res.x     <= use_w ? quo[0] * $signed({1'b0, side_w[DIV_LAT-1]}) : PROD_W'(0);
		res.y     <= use_w ? quo[1] * $signed({1'b0, side_w[DIV_LAT-1]}) : PROD_W'(0);
		res.z     <= use_w ? quo[2] * $signed({1'b0, side_w[DIV_LAT-1]}) : PROD_W'(0);
		res.degen <= side_a[DIV_LAT-1] && side_z[DIV_LAT-1];
	end

endmodule
`default_nettype wire

// ===== design/lbs_merge.sv =====
// Merge stage: sums the lane contributions, rounds and saturates.
`default_nettype none
module lbs_merge import lbs_pkg::*; (
	input  wire logic                  clk,
	input  wire lane_res_t [LANES-1:0] lane,
	output result_t                    result
);

	logic signed [ACC_W-1:0] acc_s1 [0:2];
	logic                    deg_s1;
	logic signed [ACC_W-1:0] sum_c  [0:2];
	logic                    deg_c;
	logic signed [ACC_W-16:0] shr_c [0:2];
	logic signed [31:0]      sat_c  [0:2];

	always_comb begin
		for (int c = 0; c < 3; c++)
			sum_c[c] = ACC_W'(16384);
		deg_c = 1'b0;
		for (int l = 0; l < LANES; l++) begin
			sum_c[0] = sum_c[0] + ACC_W'(lane[l].x);
			sum_c[1] = sum_c[1] + ACC_W'(lane[l].y);
			sum_c[2] = sum_c[2] + ACC_W'(lane[l].z);
			deg_c    = deg_c | lane[l].degen;
		end
	end

	// sum with rounding bias
	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++)
			acc_s1[c] <= sum_c[c];
		deg_s1 <= deg_c;
	end

	// floor shift by 15 and clamp to 32 bits
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			shr_c[c] = acc_s1[c][ACC_W-1:15];
			if (shr_c[c] > (ACC_W-15)'(32'sh7FFF_FFFF))
				sat_c[c] = 32'sh7FFF_FFFF;
			else if (shr_c[c] < (ACC_W-15)'(-64'sh8000_0000))
				sat_c[c] = 32'sh8000_0000;
			else
				sat_c[c] = shr_c[c][31:0];
		end
	end

	always_ff @(posedge clk) begin
		result.out_x      <= sat_c[0];
		result.out_y      <= sat_c[1];
		result.out_z      <= sat_c[2];
		result.degenerate <= deg_s1;
	end

endmodule
`default_nettype wire
